// ===== rtl/core/rtt_pkg.sv =====
// Package for the RTT percentile window controller.
// Holds shared constants, register indexes and sizing defaults; no dependencies.
package rtt_pkg;

   localparam int HistoryEpochs   = 4;
   localparam int SamplesPerEpoch = 256;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 17;

   localparam logic [CsrIdxW-1:0] CSR_EPOCH_LEN = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_TARGET    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_KP        = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_KD        = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_DECAY     = 3'd4;

   localparam logic OP_ACK   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [16:0] Q_ONE   = 17'd65536;
   localparam logic [31:0] WIN_ONE = 32'd256;

endpackage

// ===== rtl/core/rtt_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module rtt_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/rtt_percentile_window_controller.sv =====
// RTT percentile congestion window controller, top level.
// Uses rtt_pkg and rtt_ram (sample store and histogram memory).
//
// Usage:
//  req_ beats carry an ack (store one RTT sample) or a window query.
//  rsp_ gives one beat per query: the window in datagrams, at least 1.
//  csr_ is a plain write port for the five control registers; write only
//  while the block is idle.
// Timing:
//  Every beat first runs the epoch check. Without a decision an ack is
//  then written to the sample store, and a query has its result registered
//  once the result slot is free; only then is the next beat taken.
//  A decision walks the sample store twice (one coarse histogram pass and
//  one fine pass), reading, weighting and counting each sample into its bin,
//  and after each walk scans the 256 histogram bins until the rank is reached.
//  The histogram memory is cleared with a sweep over all 256 bins before each
//  pass; its single write port sets this cost.
//  One beat is processed at a time.
// Reset: registers take their reset values, the window becomes 1.0 and
//  no samples are held. The sample store itself is not cleared.
// Stall: a result waits in the rsp_ register; the next req_ beat is taken
//  and worked on meanwhile, but its own result waits for the slot.
module rtt_percentile_window_controller #(
   parameter int HistoryEpochs   = rtt_pkg::HistoryEpochs,
   parameter int SamplesPerEpoch = rtt_pkg::SamplesPerEpoch
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [31:0]                  req_now_ms,
   input  logic [31:0]                  req_send_time_ms,
   input  logic [31:0]                  req_ack_time_ms,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [22:0]                  rsp_window_packets,
   input  logic                         csr_write,
   input  logic [rtt_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rtt_pkg::CsrDataW-1:0] csr_wdata
);
   localparam int SlotW   = (HistoryEpochs > 1) ? $clog2(HistoryEpochs) : 1;
   localparam int SampW   = (SamplesPerEpoch > 1) ? $clog2(SamplesPerEpoch) : 1;
   localparam int CntW    = $clog2(SamplesPerEpoch + 1);
   localparam int Depth   = HistoryEpochs * SamplesPerEpoch;
   localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int TotW    = $clog2(Depth + 1);
   localparam int LcntW   = $clog2(HistoryEpochs + 1);
   localparam int RankW   = TotW + 5;

   // ---------------- configuration registers
   logic [15:0] epoch_len_ff, target_ff;
   logic signed [15:0] kp_ff, kd_ff;
   logic [16:0] decay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_len_ff <= 16'd20;
         target_ff    <= 16'd100;
         kp_ff        <= '0;
         kd_ff        <= '0;
         decay_ff     <= rtt_pkg::Q_ONE;
      end else if (csr_write) begin
         case (csr_index)
            rtt_pkg::CSR_EPOCH_LEN: epoch_len_ff <= csr_wdata[15:0];
            rtt_pkg::CSR_TARGET:    target_ff    <= csr_wdata[15:0];
            rtt_pkg::CSR_KP:        kp_ff        <= csr_wdata[15:0];
            rtt_pkg::CSR_KD:        kd_ff        <= csr_wdata[15:0];
            rtt_pkg::CSR_DECAY:     decay_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- state
   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_CLR, S_LIST, S_RD, S_MUL, S_ACC, S_HRD, S_HACC,
      S_SCAN, S_SCANW, S_SCAN2, S_ERR, S_PROD, S_SUM, S_ACK, S_QUERY
   } state_type;

   state_type state_ff;
   logic        op_ff;
   logic [31:0] now_ff, rtt_ff;
   logic [CntW-1:0] cnt_ff [HistoryEpochs];
   logic [LcntW-1:0] lists_ff;
   logic [SlotW-1:0] newest_ff;
   logic [31:0] start_ff;
   logic signed [16:0] last_err_ff;
   logic signed [31:0] win_ff;
   logic        rsp_valid_ff;
   logic [22:0] rsp_win_ff;

   // walk control
   logic        pass_ff;          // 0 coarse, 1 fine
   logic [LcntW-1:0] k_ff;        // list age
   logic [SampW:0]   j_ff;        // sample within list
   logic [16:0] mult_ff;
   logic [RankW-1:0] rank_ff;
   logic [TotW-1:0]  below_ff;
   logic [8:0]  bin_ff;
   logic [7:0]  hi_ff;
   logic [15:0] wsamp_ff;
   logic        hit_ff;
   logic [16:0] actual_ff;
   logic signed [17:0] err_ff;
   logic signed [34:0] pterm_ff, dterm_ff;

   // sample store
   logic             st_we;
   logic [AddrW-1:0] st_waddr, st_raddr;
   logic [15:0]      st_wdata, st_rdata;

   rtt_ram #(.Width(16), .Depth(Depth)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   // histogram memory, 256 bins
   logic          hg_we;
   logic [7:0]    hg_waddr, hg_raddr;
   logic [TotW-1:0] hg_wdata, hg_rdata;

   rtt_ram #(.Width(TotW), .Depth(256)) u_hist (
      .clock(clock), .wr_en(hg_we), .wr_addr(hg_waddr), .wr_data(hg_wdata),
      .rd_addr(hg_raddr), .rd_data(hg_rdata)
   );

   // ---------------- combinational helpers
   logic [SlotW-1:0] cur_slot;
   logic [SlotW-1:0] next_slot;
   logic [SlotW:0]   slot_sum;
   logic [SlotW:0]   idx_sum;
   logic [SlotW-1:0] idx_slot;
   logic [CntW-1:0]  cur_cnt;
   logic [31:0]      elapsed;
   logic [TotW-1:0]  sum_cnt;
   logic [16:0]      decay_sat;
   logic [33:0]      mprod;
   logic [32:0]      wprod;
   logic [7:0]       wkey;
   logic [TotW-1:0]  below_next;
   logic signed [35:0] win_sum;
   logic             rsp_load;

   always_comb begin
      // ring slot of list age k, wrapped with one compare
      slot_sum = (SlotW+1)'(newest_ff) + (SlotW+1)'(HistoryEpochs) - (SlotW+1)'(k_ff);
      cur_slot = (slot_sum >= (SlotW+1)'(HistoryEpochs))
               ? SlotW'(slot_sum - (SlotW+1)'(HistoryEpochs)) : SlotW'(slot_sum);
      next_slot = (newest_ff == SlotW'(HistoryEpochs - 1)) ? '0 : newest_ff + SlotW'(1);
      cur_cnt  = cnt_ff[cur_slot];
      elapsed  = now_ff - start_ff;
      decay_sat = (decay_ff > rtt_pkg::Q_ONE) ? rtt_pkg::Q_ONE : decay_ff;
      mprod    = mult_ff * decay_sat;
      wprod    = st_rdata * mult_ff;
      wkey     = pass_ff ? wsamp_ff[7:0] : wsamp_ff[15:8];
      below_next = below_ff + hg_rdata;
      win_sum  = 36'(win_ff) + 36'(pterm_ff) + 36'(dterm_ff);
      sum_cnt  = '0;
      idx_sum  = '0;
      idx_slot = '0;
      for (int i = 0; i < HistoryEpochs; i++) begin
         idx_sum = (SlotW+1)'(newest_ff) + (SlotW+1)'(HistoryEpochs) - (SlotW+1)'(i);
         idx_slot = (idx_sum >= (SlotW+1)'(HistoryEpochs))
                  ? SlotW'(idx_sum - (SlotW+1)'(HistoryEpochs)) : SlotW'(idx_sum);
         if (i < lists_ff) begin
            sum_cnt = sum_cnt + TotW'(cnt_ff[idx_slot]);
         end
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_packets = rsp_win_ff;
   assign rsp_load           = (state_ff == S_QUERY) && (!rsp_valid_ff || rsp_ready);

   // store write on ack
   assign st_we    = (state_ff == S_ACK) && (cur_cnt < CntW'(SamplesPerEpoch));
   assign st_waddr = AddrW'(32'(newest_ff) * SamplesPerEpoch + 32'(cur_cnt));
   assign st_wdata = (rtt_ff > 32'hFFFF) ? 16'hFFFF : rtt_ff[15:0];
   assign st_raddr = AddrW'(32'(cur_slot) * SamplesPerEpoch + 32'(j_ff[SampW-1:0]));

   // histogram port usage
   always_comb begin
      hg_we    = 1'b0;
      hg_waddr = bin_ff[7:0];
      hg_wdata = '0;
      hg_raddr = bin_ff[7:0];
      case (state_ff)
         S_CLR: begin
            hg_we = 1'b1;
         end
         S_ACC: begin
            hg_raddr = wkey;
         end
         S_HACC: begin
            hg_waddr = wkey;
            hg_we    = hit_ff;
            hg_wdata = hg_rdata + TotW'(1);
         end
         default: ;
      endcase
   end

   // ---------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lists_ff     <= '0;
         newest_ff    <= '0;
         start_ff     <= '0;
         last_err_ff  <= '0;
         win_ff       <= 32'sd256;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HistoryEpochs; i++) cnt_ff[i] <= '0;
      end else begin
         // result slot: load on a query, free on handshake
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_operation;
                  now_ff   <= req_now_ms;
                  rtt_ff   <= req_ack_time_ms - req_send_time_ms;
                  k_ff     <= '0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               // rank n*19/20 by reciprocal multiply
               rank_ff  <= RankW'((64'(sum_cnt) * 64'd15938359) >> 24);
               if (elapsed >= 32'(epoch_len_ff) && sum_cnt != '0) begin
                  pass_ff  <= 1'b0;
                  bin_ff   <= '0;
                  below_ff <= '0;
                  state_ff <= S_CLR;
               end else begin
                  state_ff <= (op_ff == rtt_pkg::OP_ACK) ? S_ACK : S_QUERY;
               end
            end
            // clear 256 histogram bins
            S_CLR: begin
               bin_ff <= bin_ff + 9'd1;
               if (bin_ff == 9'd255) begin
                  k_ff     <= '0;
                  j_ff     <= '0;
                  mult_ff  <= rtt_pkg::Q_ONE;
                  state_ff <= S_LIST;
               end
            end
            // walk lists newest first
            S_LIST: begin
               if (k_ff >= lists_ff || k_ff >= LcntW'(HistoryEpochs)) begin
                  bin_ff   <= '0;
                  state_ff <= S_HRD;
               end else if (j_ff >= (SampW+1)'(cur_cnt)) begin
                  mult_ff  <= mprod[32:16];
                  k_ff     <= k_ff + LcntW'(1);
                  j_ff     <= '0;
               end else begin
                  state_ff <= S_RD;
               end
            end
            S_RD: state_ff <= S_MUL;
            S_MUL: begin
               wsamp_ff <= wprod[31:16];
               hit_ff   <= !pass_ff || (wprod[31:24] == hi_ff);
               state_ff <= S_ACC;
            end
            S_ACC: state_ff <= S_HACC;
            S_HACC: begin
               j_ff     <= j_ff + (SampW+1)'(1);
               state_ff <= S_LIST;
            end
            // scan bins for the rank
            S_HRD: state_ff <= S_SCAN;
            S_SCAN: begin
               if (bin_ff == 9'd255 || RankW'(below_next) > rank_ff) begin
                  if (!pass_ff) begin
                     hi_ff    <= bin_ff[7:0];
                     rank_ff  <= rank_ff - RankW'(below_ff);
                     below_ff <= '0;
                     pass_ff  <= 1'b1;
                     bin_ff   <= '0;
                     state_ff <= S_CLR;
                  end else begin
                     actual_ff <= {1'b0, hi_ff, bin_ff[7:0]};
                     state_ff  <= S_ERR;
                  end
               end else begin
                  below_ff <= below_next;
                  bin_ff   <= bin_ff + 9'd1;
                  state_ff <= S_SCANW;
               end
            end
            S_SCANW: state_ff <= S_SCAN2;
            S_SCAN2: state_ff <= S_SCAN;
            // PD step
            S_ERR: begin
               err_ff   <= 18'sd0 + $signed({2'b0, target_ff}) - $signed({1'b0, actual_ff});
               state_ff <= S_PROD;
            end
            S_PROD: begin
               pterm_ff <= 35'(kp_ff * err_ff);
               dterm_ff <= 35'(kd_ff * (err_ff - 18'(last_err_ff)));
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (win_sum > 36'sh07FFFFFFF) win_ff <= 32'h7FFFFFFF;
               else if (win_sum < -36'sh080000000) win_ff <= 32'h80000000;
               else win_ff <= win_sum[31:0];
               last_err_ff <= err_ff[16:0];
               start_ff    <= now_ff;
               if (lists_ff < LcntW'(HistoryEpochs)) lists_ff <= lists_ff + LcntW'(1);
               newest_ff         <= next_slot;
               cnt_ff[next_slot] <= '0;
               k_ff     <= '0;
               state_ff <= (op_ff == rtt_pkg::OP_ACK) ? S_ACK : S_QUERY;
            end
            S_ACK: begin
               if (lists_ff == '0) begin
                  lists_ff <= LcntW'(1);
                  cnt_ff[newest_ff] <= CntW'(1);
               end else if (cur_cnt < CntW'(SamplesPerEpoch)) begin
                  cnt_ff[newest_ff] <= cur_cnt + CntW'(1);
               end
               state_ff <= S_IDLE;
            end
            S_QUERY: begin
               if (rsp_load) begin
                  if (win_ff < 32'sd256) begin
                     win_ff     <= 32'sd256;
                     rsp_win_ff <= 23'd1;
                  end else begin
                     rsp_win_ff <= win_ff[30:8];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
